// ===== sv/cfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// cfp_pkg
// Types and constants shared by the checksum frame parser modules.
// -----------------------------------------------------------------------------
package cfp_pkg;

	// Frame layout
	localparam int unsigned HEADER_BYTES  = 5;
	localparam int unsigned TRAILER_BYTES = 2;
	localparam int unsigned CMD_BYTES     = 4;
	localparam int unsigned CNT_W         = 9;
	localparam int unsigned POS_W         = CNT_W + 1;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// Result kind
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Verdict status codes
	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_TOO_SHORT    = 2'd1,
		ST_LEN_MISMATCH = 2'd2,
		ST_SUM_MISMATCH = 2'd3
	} status_t;

	// One result beat
	typedef struct packed {
		logic        kind;
		logic [7:0]  payload_byte;
		status_t     status;
		logic [31:0] command_word;
		logic [7:0]  payload_length;
		logic [15:0] received_checksum;
	} result_t;

endpackage : cfp_pkg
`default_nettype wire

// ===== sv/cfp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// cfp_byte_if / cfp_result_if
// Valid/ready channels for frame bytes in and parser results out.
// -----------------------------------------------------------------------------
interface cfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_frame;

	modport source (output valid, output data_byte, output end_of_frame, input ready);
	modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface : cfp_byte_if

interface cfp_result_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  payload_byte;
	logic [1:0]  status;
	logic [31:0] command_word;
	logic [7:0]  payload_length;
	logic [15:0] received_checksum;

	modport source (output valid, output kind, output payload_byte, output status,
		output command_word, output payload_length, output received_checksum,
		input ready);
	modport sink   (input valid, input kind, input payload_byte, input status,
		input command_word, input payload_length, input received_checksum,
		output ready);
endinterface : cfp_result_if
`default_nettype wire

// ===== sv/cfp_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// cfp_parse
// Per-frame state and the single-pass decode of one accepted byte beat.
// -----------------------------------------------------------------------------
module cfp_parse (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  take,
	input  wire [7:0]            data_byte,
	input  wire                  end_of_frame,
	output logic                 res_valid,
	output cfp_pkg::result_t     res
);
	import cfp_pkg::*;

	logic [CNT_W-1:0] cnt_q, cnt_nxt;
	logic [31:0]      cmd_q, cmd_nxt;
	logic [7:0]       len_q, len_nxt;
	logic [15:0]      sum_q, sum_nxt;
	logic [15:0]      held_q, held_nxt;
	logic [POS_W-1:0] pos_w;
	logic [7:0]       len_v;
	logic             in_payload;
	status_t          status;

	// Next frame state for this byte
	always_comb begin
		pos_w   = {1'b0, cnt_q};
		cmd_nxt = cmd_q;
		if (cnt_q < CNT_W'(CMD_BYTES)) begin
			cmd_nxt[{cnt_q[1:0], 3'b000} +: 8] = data_byte;
		end
		len_nxt  = (cnt_q == CNT_W'(CMD_BYTES)) ? data_byte : len_q;
		sum_nxt  = (cnt_q >= CNT_W'(2)) ? sum_q + {8'd0, held_q[15:8]} : sum_q;
		held_nxt = {held_q[7:0], data_byte};
		cnt_nxt  = (cnt_q < COUNT_MAX) ? cnt_q + CNT_W'(1) : cnt_q;
		in_payload = (cnt_q >= CNT_W'(HEADER_BYTES)) &&
			(pos_w < POS_W'(HEADER_BYTES) + {2'b00, len_nxt});
	end

	// Verdict, checks in priority order
	always_comb begin
		len_v = (cnt_q >= CNT_W'(CMD_BYTES)) ? len_nxt : 8'd0;
		if (cnt_q < CNT_W'(HEADER_BYTES + TRAILER_BYTES - 1)) begin
			status = ST_TOO_SHORT;
		end else if (pos_w != POS_W'(HEADER_BYTES + TRAILER_BYTES - 1) + {2'b00, len_v}) begin
			status = ST_LEN_MISMATCH;
		end else if (~sum_nxt != held_nxt) begin
			status = ST_SUM_MISMATCH;
		end else begin
			status = ST_OK;
		end
	end

	// Result beat
	always_comb begin
		res = '0;
		res_valid = 1'b0;
		if (end_of_frame) begin
			res_valid             = take;
			res.kind              = KIND_VERDICT;
			res.status            = status;
			res.command_word      = cmd_nxt;
			res.payload_length    = len_v;
			res.received_checksum = held_nxt;
		end else begin
			res_valid        = take && in_payload;
			res.kind         = KIND_PAYLOAD;
			res.payload_byte = data_byte;
		end
	end

	// Frame state registers; all but the length byte are cleared after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			cmd_q  <= '0;
			len_q  <= '0;
			sum_q  <= '0;
			held_q <= '0;
		end else if (take) begin
			len_q <= len_nxt;
			if (end_of_frame) begin
				cnt_q  <= '0;
				cmd_q  <= '0;
				sum_q  <= '0;
				held_q <= '0;
			end else begin
				cnt_q  <= cnt_nxt;
				cmd_q  <= cmd_nxt;
				sum_q  <= sum_nxt;
				held_q <= held_nxt;
			end
		end
	end

endmodule : cfp_parse
`default_nettype wire

// ===== sv/cfp_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// cfp_out_buf
// Two-entry result register: holds a finished beat while the next is decoded.
// -----------------------------------------------------------------------------
module cfp_out_buf (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  wr_en,
	input  cfp_pkg::result_t     wr_data,
	output logic                 not_full,
	output logic                 rd_valid,
	input  wire                  rd_ready,
	output cfp_pkg::result_t     rd_data
);
	import cfp_pkg::*;

	result_t    ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       rd_en;

	assign not_full = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_en    = rd_valid && rd_ready;
	assign rd_data  = ent_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule : cfp_out_buf
`default_nettype wire

// ===== sv/checksum_frame_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// checksum_frame_parser
// Streaming parser for length-prefixed frames with a complemented 16-bit sum.
//
//   channel    | dir | payload
//   -----------+-----+----------------------------------------------------------
//   byte_ch    | in  | data_byte, end_of_frame
//   result_ch  | out | kind, payload_byte, status, command_word, payload_length,
//              |     | received_checksum
//
// One byte beat per cycle; each result is buffered when its byte is taken and
// leaves on result_ch in order. The two-entry result buffer sets the rate:
// byte_ch.ready drops only while both entries are occupied. Reset clears the
// frame state and the buffer; the stored length byte also resets to zero.
// -----------------------------------------------------------------------------
module checksum_frame_parser (
	input wire             clk,
	input wire             arst_n,
	cfp_byte_if.sink       byte_ch,
	cfp_result_if.source   result_ch
);
	import cfp_pkg::*;

	logic    take;
	logic    buf_not_full;
	logic    res_valid;
	result_t res;
	result_t out_res;

	assign byte_ch.ready = buf_not_full;
	assign take          = byte_ch.valid && buf_not_full;

	// Byte decode and frame state
	cfp_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.data_byte    (byte_ch.data_byte),
		.end_of_frame (byte_ch.end_of_frame),
		.res_valid    (res_valid),
		.res          (res)
	);

	// Result register
	cfp_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (res_valid),
		.wr_data  (res),
		.not_full (buf_not_full),
		.rd_valid (result_ch.valid),
		.rd_ready (result_ch.ready),
		.rd_data  (out_res)
	);

	assign result_ch.kind              = out_res.kind;
	assign result_ch.payload_byte      = out_res.payload_byte;
	assign result_ch.status            = out_res.status;
	assign result_ch.command_word      = out_res.command_word;
	assign result_ch.payload_length    = out_res.payload_length;
	assign result_ch.received_checksum = out_res.received_checksum;

endmodule : checksum_frame_parser
`default_nettype wire
